// File: src/cmb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cmb_pkg
// Shared types and constants of the crossover mask builder: request codes,
// field layout of the stream words and the mask store control bundle.
// ----------------------------------------------------------------------------
package cmb_pkg;

  localparam int REQ_W      = 2;
  localparam int COUNT_W    = 11;
  localparam int IDX_W      = 10;
  localparam int POS_W      = 32;
  localparam int IN_DATA_W  = 48;
  localparam int WORD_IDX_W = 4;
  localparam int MASK_W     = 64;

  // in_tdata layout, lowest bit up
  localparam int IDX_LSB  = 0;
  localparam int POS_LSB  = IDX_LSB + IDX_W;
  localparam int TAPE_BIT = POS_LSB + POS_W;

  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_XOVER = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLOSE = 2'd2;

  localparam logic [COUNT_W-1:0] MARKER_COUNT_RESET = 11'd1024;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear;
  } mask_ctl_t;

endpackage
`default_nettype wire

// File: src/cmb_mask_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cmb_mask_store
// Mask word memory with registered read. A valid bit per word
// makes unwritten or cleared words read as zero, so reset and gamete close
// clear the whole mask at once.
// ----------------------------------------------------------------------------
module cmb_mask_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  cmb_pkg::mask_ctl_t              ctl,
  input  wire  [AW-1:0]                   rd_addr,
  output logic [cmb_pkg::MASK_W-1:0]      rd_data,
  input  wire  [AW-1:0]                   wr_addr,
  input  wire  [cmb_pkg::MASK_W-1:0]      wr_data
);

  logic [cmb_pkg::MASK_W-1:0] mem_r [DEPTH];
  logic [DEPTH-1:0]           vld_r;
  logic [cmb_pkg::MASK_W-1:0] rd_raw_r;
  logic                       rd_vld_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_raw_r <= mem_r[rd_addr];
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl.clear) begin
      vld_r <= '0;
    end else if (ctl.wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_vld_r ? rd_raw_r : '0;

endmodule
`default_nettype wire

// File: src/crossover_mask_builder.sv
`default_nettype none
// Load word: written to the marker table when accepted. Crossover word: accepted, then one
//   dependent table probe per cycle, then read-modify-write of the mask words that hold
//   bits 0..k-1, k = N - b (skipped when k is 0).
// Close word: accepted, then each mask word is read, then loaded once the output register is free.
// Reset (rst_n low, synchronous): control cleared, marker_count = 1024,
//   mask reads all zeros at once; marker table is not cleared.
// ----------------------------------------------------------------------------
// crossover_mask_builder
// Sorted marker table with binary search, and a multi-word crossover mask
// that is toggled per crossover point and emitted on close.
// ----------------------------------------------------------------------------
module crossover_mask_builder #(
  parameter int MAX_MARKERS   = 1024,
  parameter int POSITION_BITS = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  // configuration
  input  wire         cfg_wr_en,
  input  wire  [10:0] cfg_wr_data,   // marker_count
  // request stream
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [47:0] in_tdata,      // marker_index[9:0], position[41:10], tape[42], zero pad
  input  wire  [1:0]  in_tuser,      // req_type[1:0]
  // mask stream
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [63:0] out_tdata,     // mask_word[63:0]
  output logic [3:0]  out_tuser,     // word_index[3:0]
  output logic        out_tlast
);

  localparam int AW         = (MAX_MARKERS > 1) ? $clog2(MAX_MARKERS) : 1;
  localparam int NW         = $clog2(MAX_MARKERS + 1);
  localparam int MASK_DEPTH = (MAX_MARKERS + 63) / 64;
  localparam int WW         = (MASK_DEPTH > 1) ? $clog2(MASK_DEPTH) : 1;
  localparam int CW         = WW + 1;
  localparam int LW         = ((NW > WW + 6) ? NW : WW + 6) + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SRCH  = 3'd1;
  localparam logic [2:0] S_TGL   = 3'd2;
  localparam logic [2:0] S_CL_RD = 3'd3;
  localparam logic [2:0] S_CL_LD = 3'd4;

  // bits 0..k-1 of the whole mask, as seen in word w
  function automatic logic [63:0] low_bits(input logic [NW-1:0] k, input logic [WW-1:0] w);
    logic [LW-1:0] base;
    logic [LW-1:0] kk;
    logic [LW-1:0] d;
    logic [63:0]   res;
    base = LW'({w, 6'b0});
    kk   = LW'(k);
    d    = kk - base;
    if (kk <= base) begin
      res = '0;
    end else if (d >= LW'(64)) begin
      res = '1;
    end else begin
      res = ~({64{1'b1}} << d[5:0]);
    end
    return res;
  endfunction

  logic [2:0]                 state_r, state_nxt;
  logic [10:0]                count_r;
  logic [POSITION_BITS-1:0]   pos_r, pos_nxt;
  logic                       tape_r, tape_nxt;
  logic [NW-1:0]              lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt, k_r, k_nxt;
  logic                       pend_r, pend_nxt;
  logic [CW-1:0]              rd_w_r, rd_w_nxt;
  logic                       wb_pend_r, wb_pend_nxt;
  logic [WW-1:0]              wb_w_r, wb_w_nxt;
  logic [WW-1:0]              cl_w_r, cl_w_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [63:0]                out_data_r, out_data_nxt;
  logic [3:0]                 out_idx_r, out_idx_nxt;
  logic                       out_last_r, out_last_nxt;

  logic                       in_acc;
  logic [1:0]                 in_req;
  logic [9:0]                 in_idx;
  logic [POSITION_BITS-1:0]   in_pos;
  logic                       in_tape;

  logic [NW-1:0]              n_act;
  logic [CW-1:0]              n_words;
  logic [CW-1:0]              k_words;
  logic [LW-1:0]              n_sum, k_sum;

  logic [POSITION_BITS-1:0]   mk_mem_r [MAX_MARKERS];
  logic [POSITION_BITS-1:0]   mk_rd_r;
  logic                       mk_we, mk_re;
  logic [AW-1:0]              mk_wa;
  logic [NW-1:0]              lo_cur, hi_cur, mid;
  logic                       srch_go;

  cmb_pkg::mask_ctl_t         ms_ctl;
  logic [WW-1:0]              ms_ra;
  logic [63:0]                ms_rd;
  logic [63:0]                ms_wd;
  logic                       out_free;
  logic [63:0]                cl_word;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_req    = in_tuser;
  assign in_idx    = in_tdata[cmb_pkg::IDX_LSB +: cmb_pkg::IDX_W];
  assign in_pos    = POSITION_BITS'(in_tdata[cmb_pkg::POS_LSB +: cmb_pkg::POS_W]);
  assign in_tape   = in_tdata[cmb_pkg::TAPE_BIT];

  // active marker count: zero reads as one, saturate at table size
  always_comb begin
    if (count_r == '0) begin
      n_act = NW'(1);
    end else if (32'(count_r) > MAX_MARKERS) begin
      n_act = NW'(MAX_MARKERS);
    end else begin
      n_act = NW'(count_r);
    end
  end

  assign n_sum   = LW'(n_act) + LW'(63);
  assign k_sum   = LW'(k_r) + LW'(63);
  assign n_words = CW'(n_sum >> 6);
  assign k_words = CW'(k_sum >> 6);

  // marker table
  assign mk_we = in_acc && (in_req == cmb_pkg::REQ_LOAD) && (32'(in_idx) < MAX_MARKERS);
  assign mk_wa = AW'(in_idx);

  always_ff @(posedge clk) begin
    if (mk_we) begin
      mk_mem_r[mk_wa] <= in_pos;
    end
    if (mk_re) begin
      mk_rd_r <= mk_mem_r[mid[AW-1:0]];
    end
  end

  // fold the returned probe into the bounds, then issue the next probe
  always_comb begin
    lo_cur = lo_r;
    hi_cur = hi_r;
    if (pend_r) begin
      if (mk_rd_r <= pos_r) begin
        lo_cur = mid_r + NW'(1);
      end else begin
        hi_cur = mid_r;
      end
    end
    mid     = NW'(((NW+1)'(lo_cur) + (NW+1)'(hi_cur)) >> 1);
    srch_go = (lo_cur < hi_cur);
    mk_re   = (state_r == S_SRCH) && srch_go;
  end

  assign out_free = !out_valid_r || out_tready;
  assign ms_wd    = ms_rd ^ low_bits(k_r, wb_w_r);
  assign cl_word  = (tape_r ? ~ms_rd : ms_rd) & low_bits(n_act, cl_w_r);

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    tape_nxt      = tape_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    k_nxt         = k_r;
    pend_nxt      = 1'b0;
    rd_w_nxt      = rd_w_r;
    wb_pend_nxt   = 1'b0;
    wb_w_nxt      = wb_w_r;
    cl_w_nxt      = cl_w_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;
    ms_ctl        = '0;
    ms_ra         = cl_w_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          pos_nxt  = in_pos;
          tape_nxt = in_tape;
          if (in_req == cmb_pkg::REQ_XOVER) begin
            lo_nxt    = '0;
            hi_nxt    = n_act;
            state_nxt = S_SRCH;
          end else if (in_req == cmb_pkg::REQ_CLOSE) begin
            cl_w_nxt  = '0;
            state_nxt = S_CL_RD;
          end
        end
      end
      S_SRCH: begin
        lo_nxt   = lo_cur;
        hi_nxt   = hi_cur;
        mid_nxt  = mid;
        pend_nxt = srch_go;
        if (!srch_go) begin
          k_nxt     = n_act - lo_cur;
          rd_w_nxt  = '0;
          state_nxt = (n_act == lo_cur) ? S_IDLE : S_TGL;
        end
      end
      S_TGL: begin
        // read word w+1 while word w is written back
        ms_ctl.wr_en = wb_pend_r;
        ms_ctl.rd_en = (rd_w_r < k_words);
        ms_ra        = rd_w_r[WW-1:0];
        if (ms_ctl.rd_en) begin
          wb_pend_nxt = 1'b1;
          wb_w_nxt    = rd_w_r[WW-1:0];
          rd_w_nxt    = rd_w_r + CW'(1);
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_CL_RD: begin
        ms_ctl.rd_en = 1'b1;
        state_nxt    = S_CL_LD;
      end
      S_CL_LD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = cl_word;
          out_idx_nxt   = 4'(cl_w_r);
          out_last_nxt  = (CW'(cl_w_r) + CW'(1) == n_words);
          if (CW'(cl_w_r) + CW'(1) == n_words) begin
            ms_ctl.clear = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            cl_w_nxt  = cl_w_r + WW'(1);
            state_nxt = S_CL_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= cmb_pkg::MARKER_COUNT_RESET;
      pend_r      <= 1'b0;
      wb_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      wb_pend_r   <= wb_pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        count_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    tape_r     <= tape_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    k_r        <= k_nxt;
    rd_w_r     <= rd_w_nxt;
    wb_w_r     <= wb_w_nxt;
    cl_w_r     <= cl_w_nxt;
    out_data_r <= out_data_nxt;
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
  end

  cmb_mask_store #(
    .DEPTH (MASK_DEPTH),
    .AW    (WW)
  ) u_mask (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ms_ctl),
    .rd_addr (ms_ra),
    .rd_data (ms_rd),
    .wr_addr (wb_w_r),
    .wr_data (ms_wd)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_idx_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

// File: src/cmb_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cmb_checker
// Port-level checks of the crossover mask builder, bound to the top level.
// ----------------------------------------------------------------------------
module cmb_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire [1:0]  in_tuser,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [63:0] out_tdata,
  input wire [3:0]  out_tuser,
  input wire        out_tlast
);

  // a stalled word stays offered and unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("out word dropped under backpressure");

  // reset empties the output register
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out word valid after reset");

  // a crossover or close word occupies the block
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready &&
    (in_tuser == cmb_pkg::REQ_XOVER || in_tuser == cmb_pkg::REQ_CLOSE)
    |=> !in_tready)
    else $error("request taken while a word is in progress");

  // a load leaves the input ready
  a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == cmb_pkg::REQ_LOAD |=> in_tready)
    else $error("load stalled the input");

  // mask words of one gamete come in index order
  a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && $past(out_tvalid && out_tready && !out_tlast)
    |-> out_tuser == 4'($past(out_tuser) + 4'd1))
    else $error("mask word index out of order");

endmodule

bind crossover_mask_builder cmb_checker u_cmb_checker (.*);
`default_nettype wire

// File: verif/crossover_mask_checker.sv
// ----------------------------------------------------------------------------
// crossover_mask_checker
// Watches the request, configuration and mask streams of the crossover mask
// builder. It keeps its own marker table, mask and marker count, predicts
// the mask words of every close request and compares each emitted word in
// order. It also counts mismatches and requests.
// ----------------------------------------------------------------------------
module crossover_mask_checker
  import cmb_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   cfg_wr_en,
  input  wire [COUNT_W-1:0]     cfg_wr_data,
  input  wire                   in_tvalid,
  input  wire                   in_tready,
  input  wire [IN_DATA_W-1:0]   in_tdata,
  input  wire [REQ_W-1:0]       in_tuser,
  input  wire                   out_tvalid,
  input  wire                   out_tready,
  input  wire [MASK_W-1:0]      out_tdata,
  input  wire [WORD_IDX_W-1:0]  out_tuser,
  input  wire                   out_tlast,
  output int unsigned           fail_count,
  output int unsigned           pending,
  output int unsigned           load_count,
  output int unsigned           xover_count,
  output int unsigned           close_count,
  output int unsigned           ignored_count,
  output int unsigned           words_checked,
  output int unsigned           count_writes
);

  localparam int TABLE_DEPTH = 1024;
  localparam int MASK_DEPTH  = 16;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic [WORD_IDX_W-1:0] word_index;
    logic [MASK_W-1:0]     mask_word;
    logic                  is_last;
  } mask_beat_t;

  logic [POS_W-1:0]   marker_tbl [0:TABLE_DEPTH-1];
  logic [MASK_W-1:0]  mask_mem   [0:MASK_DEPTH-1];
  logic [COUNT_W-1:0] count_reg;
  mask_beat_t         expected_words [$];

  initial begin
    fail_count    = 0;
    pending       = 0;
    load_count    = 0;
    xover_count   = 0;
    close_count   = 0;
    ignored_count = 0;
    words_checked = 0;
    count_writes  = 0;
  end

  // zero and oversized counts fold into the table range
  function automatic int unsigned active_count();
    int unsigned n;
    n = count_reg;
    if (n == 0) begin
      n = 1;
    end
    if (n > TABLE_DEPTH) begin
      n = TABLE_DEPTH;
    end
    return n;
  endfunction

  // number of leading table entries at or below the point
  function automatic int unsigned marker_rank(input logic [POS_W-1:0] point,
                                              input int unsigned n);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = n;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (marker_tbl[mid] <= point) begin
        lo = mid + 1;
      end else begin
        hi = mid;
      end
    end
    return lo;
  endfunction

  // bits 0..k-1 of the whole mask, as seen in word w
  function automatic logic [MASK_W-1:0] low_mask(input int unsigned k,
                                                 input int unsigned w);
    int unsigned base;
    base = w * MASK_W;
    if (k <= base) begin
      return '0;
    end
    if (k - base >= MASK_W) begin
      return '1;
    end
    return (64'd1 << (k - base)) - 64'd1;
  endfunction

  task automatic apply_request(input logic [REQ_W-1:0] req,
                               input logic [IN_DATA_W-1:0] data);
    logic [IDX_W-1:0] idx;
    logic [POS_W-1:0] pos;
    logic             tape;
    int unsigned      n;
    int unsigned      k;
    int unsigned      words;
    logic [MASK_W-1:0] v;
    mask_beat_t       beat;
    idx  = data[IDX_LSB +: IDX_W];
    pos  = data[POS_LSB +: POS_W];
    tape = data[TAPE_BIT];
    n    = active_count();
    case (req)
      REQ_LOAD: begin
        marker_tbl[idx] = pos;
        load_count++;
      end
      REQ_XOVER: begin
        k = n - marker_rank(pos, n);
        for (int w = 0; w < MASK_DEPTH; w++) begin
          mask_mem[w] = mask_mem[w] ^ low_mask(k, w);
        end
        xover_count++;
      end
      REQ_CLOSE: begin
        words = (n + MASK_W - 1) / MASK_W;
        for (int w = 0; w < words; w++) begin
          v = tape ? ~mask_mem[w] : mask_mem[w];
          beat.word_index = w[WORD_IDX_W-1:0];
          beat.mask_word  = v & low_mask(n, w);
          beat.is_last    = (w + 1 == words);
          expected_words.push_back(beat);
        end
        for (int w = 0; w < MASK_DEPTH; w++) begin
          mask_mem[w] = '0;
        end
        close_count++;
      end
      default: begin
        ignored_count++;
      end
    endcase
  endtask

  task automatic check_word();
    mask_beat_t want;
    if (expected_words.size() == 0) begin
      fail_count++;
      if (fail_count <= REPORT_MAX) begin
        $display("[%0t] unexpected mask word: index %0d data %h last %b",
                 $realtime, out_tuser, out_tdata, out_tlast);
      end
      return;
    end
    want = expected_words.pop_front();
    words_checked++;
    if (out_tuser !== want.word_index || out_tdata !== want.mask_word ||
        out_tlast !== want.is_last) begin
      fail_count++;
      if (fail_count <= REPORT_MAX) begin
        $display("[%0t] mask word mismatch: expected index %0d data %h last %b",
                 $realtime, want.word_index, want.mask_word, want.is_last);
        $display("[%0t]                       actual index %0d data %h last %b",
                 $realtime, out_tuser, out_tdata, out_tlast);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      count_reg = MARKER_COUNT_RESET;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        marker_tbl[i] = '0;
      end
      for (int w = 0; w < MASK_DEPTH; w++) begin
        mask_mem[w] = '0;
      end
      expected_words.delete();
    end else begin
      // compare first: a word leaving now belongs to an older close
      if (out_tvalid && out_tready) begin
        check_word();
      end
      if (cfg_wr_en) begin
        count_reg = cfg_wr_data;
        count_writes++;
      end
      if (in_tvalid && in_tready) begin
        apply_request(in_tuser, in_tdata);
      end
    end
    pending = expected_words.size();
  end

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the crossover mask builder. A short directed run
// with one and two markers, a sorted load of the leading table entries,
// closes under oversized marker counts, then random requests across several
// marker counts with random gaps on both streams, except in the last phase. The
// checker beside the block predicts and compares every mask word.
// ----------------------------------------------------------------------------
module testbench;
  import cmb_pkg::*;

  localparam logic [REQ_W-1:0] REQ_RESERVED = 2'd3;
  localparam int TABLE_DEPTH    = 1024;
  localparam int FILL_DEPTH     = 130;
  localparam int PHASE_ITEMS    = 20;
  localparam int SETTLE_CYCLES  = 64;
  localparam int WATCHDOG_LIMIT = 4000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [COUNT_W-1:0]    cfg_wr_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [REQ_W-1:0]      in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [MASK_W-1:0]     out_tdata;
  logic [WORD_IDX_W-1:0] out_tuser;
  logic                  out_tlast;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned load_count;
  int unsigned xover_count;
  int unsigned close_count;
  int unsigned ignored_count;
  int unsigned words_checked;
  int unsigned count_writes;

  logic [POS_W-1:0] marker_pos [0:TABLE_DEPTH-1];
  int unsigned      n_active = TABLE_DEPTH;
  logic             quiet = 1'b0;
  int unsigned      idle_cycles = 0;

  always #6 clk = ~clk;

  crossover_mask_builder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  crossover_mask_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast),
    .fail_count   (fail_count),
    .pending      (pending),
    .load_count   (load_count),
    .xover_count  (xover_count),
    .close_count  (close_count),
    .ignored_count(ignored_count),
    .words_checked(words_checked),
    .count_writes (count_writes)
  );

  // end the run when neither stream moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("crossover_mask_builder test failed");
      $finish;
    end
  end

  // mask sink: random stall bursts, always ready once quiet
  initial begin
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(negedge clk);
    end
  end

  // drive one request word and hold it until accepted; ends on a falling edge
  task automatic send_word(input logic [REQ_W-1:0] req, input logic [IDX_W-1:0] idx,
                           input logic [POS_W-1:0] pos, input logic tape);
    logic [IN_DATA_W-1:0] packed_word;
    packed_word = '0;
    packed_word[IDX_LSB +: IDX_W] = idx;
    packed_word[POS_LSB +: POS_W] = pos;
    packed_word[TAPE_BIT]         = tape;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= packed_word;
    in_tuser  <= req;
    if (req == REQ_LOAD) begin
      marker_pos[idx] = pos;
    end
    do begin
      @(posedge clk);
    end while (!in_tready);
    @(negedge clk);
  endtask

  // drain, let the block finish any crossover, then change the marker count
  task automatic write_marker_count(input logic [COUNT_W-1:0] value);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    n_active = (value == 0) ? 1 : (value > TABLE_DEPTH) ? TABLE_DEPTH : value;
  endtask

  // crossover points cluster on marker positions to hit the compare edges
  function automatic logic [POS_W-1:0] pick_point();
    logic [POS_W-1:0] m;
    m = marker_pos[$urandom_range(0, n_active - 1)];
    case ($urandom_range(0, 6))
      0, 1:    return m;
      2:       return m + 1;
      3:       return m - 1;
      4:       return '0;
      5:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_request();
    int unsigned      r;
    logic [IDX_W-1:0] idx;
    logic [POS_W-1:0] pos;
    r   = $urandom_range(0, 99);
    idx = IDX_W'($urandom);
    pos = $urandom;
    if (r < 55) begin
      send_word(REQ_XOVER, idx, pick_point(), 1'($urandom));
    end else if (r < 75) begin
      send_word(REQ_CLOSE, idx, pos, 1'($urandom));
    end else if (r < 95) begin
      // half nudge an entry, half overwrite it; either may unsort the table
      if ($urandom_range(0, 1) == 0) begin
        pos = marker_pos[idx] ^ (32'd1 << $urandom_range(0, 3));
      end
      send_word(REQ_LOAD, idx, pos, 1'($urandom));
    end else begin
      send_word(REQ_RESERVED, idx, pos, 1'($urandom));
    end
  endtask

  initial begin
    logic [POS_W-1:0]   acc;
    logic [COUNT_W-1:0] phase_counts [0:7];
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      marker_pos[i] = '0;
    end
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // one marker, then two, with a count change while the mask is open
    write_marker_count(11'd1);
    send_word(REQ_LOAD,  10'd0,   32'h8000_0000, 1'b0);
    send_word(REQ_LOAD,  10'd1,   32'hFFFF_FFFF, 1'b1);
    send_word(REQ_LOAD,  10'd1023, 32'h0000_0000, 1'b0);
    send_word(REQ_XOVER, 10'd0,   32'h0000_0000, 1'b0);
    send_word(REQ_CLOSE, 10'd0,   32'h0000_0000, 1'b0);
    send_word(REQ_XOVER, 10'd0,   32'h8000_0000, 1'b1);
    send_word(REQ_XOVER, 10'h3FF, 32'hFFFF_FFFF, 1'b0);
    send_word(REQ_CLOSE, 10'h3FF, 32'hFFFF_FFFF, 1'b1);
    send_word(REQ_RESERVED, 10'h3FF, 32'hFFFF_FFFF, 1'b1);
    send_word(REQ_XOVER, 10'd0,   32'h7FFF_FFFF, 1'b0);
    write_marker_count(11'd2);
    send_word(REQ_XOVER, 10'd0,   32'h8000_0000, 1'b0);
    send_word(REQ_XOVER, 10'd0,   32'hFFFF_FFFF, 1'b0);
    send_word(REQ_XOVER, 10'd0,   32'h0000_0000, 1'b0);
    send_word(REQ_CLOSE, 10'd0,   32'h0000_0000, 1'b1);
    write_marker_count(11'd0);
    send_word(REQ_CLOSE, 10'd0,   32'h0000_0000, 1'b1);

    // fill the leading table entries in ascending order, with some repeats
    acc = $urandom_range(0, 1000);
    for (int i = 0; i < FILL_DEPTH; i++) begin
      if ($urandom_range(0, 3) != 0) begin
        acc = acc + $urandom_range(1, 4_000_000);
      end
      send_word(REQ_LOAD, i[IDX_W-1:0], (i == FILL_DEPTH - 1) ? '1 : acc, 1'($urandom));
    end

    // crossovers under the filled count, then oversized counts saturate to the full mask on close
    write_marker_count(COUNT_W'(FILL_DEPTH));
    send_word(REQ_XOVER, 10'd0, pick_point(), 1'b0);
    send_word(REQ_XOVER, 10'd0, pick_point(), 1'b0);
    send_word(REQ_XOVER, 10'd0, pick_point(), 1'b0);
    write_marker_count(11'd2047);
    send_word(REQ_CLOSE, 10'd0, 32'h0000_0000, 1'b1);
    write_marker_count(11'd1025);
    send_word(REQ_CLOSE, 10'd0, 32'h0000_0000, 1'b0);

    phase_counts[0] = COUNT_W'(FILL_DEPTH);
    phase_counts[1] = 11'd64;
    phase_counts[2] = 11'd65;
    phase_counts[3] = COUNT_W'($urandom_range(2, FILL_DEPTH));
    phase_counts[4] = 11'd1;
    phase_counts[5] = 11'd129;
    phase_counts[6] = 11'd128;
    phase_counts[7] = COUNT_W'($urandom_range(2, FILL_DEPTH));
    for (int p = 0; p < 8; p++) begin
      write_marker_count(phase_counts[p]);
      if (p == 7) begin
        quiet = 1'b1;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        random_request();
      end
    end

    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Sent %0d loads, %0d crossover points, %0d closes and %0d reserved words",
             load_count, xover_count, close_count, ignored_count);
    $display("under %0d marker count writes; %0d mask words compared.",
             count_writes, words_checked);
    if (fail_count == 0 && pending == 0) begin
      $display("crossover_mask_builder test passed");
    end else begin
      $display("crossover_mask_builder test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/cmb_pkg.sv
src/cmb_mask_store.sv
src/crossover_mask_builder.sv
src/cmb_checker.sv
verif/crossover_mask_checker.sv
verif/testbench.sv
